// ----- rtl/core/mfpm_pkg.sv -----
// package for the mesh face pair matcher
// table sizes, field widths, hash constant and memory entry types
// no dependencies
`default_nettype none

package mfpm_pkg;

  localparam int BUCKETS    = 4096;
  localparam int MAX_FACES  = 4096;
  localparam int POINT_BITS = 20;
  localparam int ELEM_BITS  = 20;
  localparam int BKT_BITS   = $clog2(BUCKETS);
  localparam int SLOT_BITS  = $clog2(MAX_FACES);
  localparam int CNT_BITS   = SLOT_BITS + 1;
  localparam int SIZE_BITS  = 13;
  localparam int PAIR_BITS  = 13;

  // 0.32 fixed-point golden ratio fraction
  localparam logic [31:0] GOLDEN_Q32 = 32'h9E37_79B9;
  localparam logic [PAIR_BITS-1:0] COUNT_MAX = {PAIR_BITS{1'b1}};

  typedef struct packed {
    logic [CNT_BITS-1:0]  count;
    logic [SLOT_BITS-1:0] head;
  } bkt_entry_t;

  typedef struct packed {
    logic [POINT_BITS-1:0] start_pt;
    logic [POINT_BITS-1:0] end_pt;
    logic [ELEM_BITS-1:0]  element;
    logic                  paired;
    logic [SLOT_BITS-1:0]  link;
  } store_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/mesh_face_pair_matcher_top.sv -----
// mesh face pair matcher: hashes directed element edges into chained buckets
// and pairs each edge with a stored opposite edge; depends on mfpm_pkg
`default_nettype none

// usage
// - in_* carries one directed edge per item (start point, end point, owning
//   element); out_* returns exactly one result item per input item, in order
// - cfg_we/cfg_wdata set the number of hash buckets in use (0 reads as 1,
//   anything above 4096 as 4096); write only while the block is idle
// - one edge is worked on at a time: two multiply stages (golden ratio hash,
//   then scaling to the bucket range), a bucket memory read, a read of each
//   chain entry visited in the edge store, then on a miss a write to append
//   the new edge and, on a non-empty chain, a write to link it behind the tail
// - after reset the bucket counts are swept to zero, one bucket per cycle,
//   with in_tready low meanwhile; config writes are taken during the sweep
// - the result sits in an output register, so the next edge is taken while
//   a result waits; a stalled receiver holds the block only when a second
//   result is ready to be handed over

module mesh_face_pair_matcher_top (
  input  wire         clk,
  input  wire         rst_n,
  // cfg: table size, 13 bits
  input  wire         cfg_we,
  input  wire  [12:0] cfg_wdata,
  input  wire         in_tvalid,
  output logic        in_tready,
  // in_tdata: point_a[19:0], point_b[39:20], element_index[59:40], zero pad
  input  wire  [63:0] in_tdata,
  output logic        out_tvalid,
  input  wire         out_tready,
  // out_tdata: first_element[19:0], second_element[39:20], edge_start[59:40],
  //            edge_end[79:60], pair_count[92:80], zero pad
  output logic [95:0] out_tdata,
  // out_tuser: matched[0], overflow[1]
  output logic [1:0]  out_tuser
);
  import mfpm_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL1   = 4'd1;
  localparam logic [3:0] S_MUL2   = 4'd2;
  localparam logic [3:0] S_BREAD  = 4'd3;
  localparam logic [3:0] S_BWAIT  = 4'd4;
  localparam logic [3:0] S_WALK   = 4'd5;
  localparam logic [3:0] S_MISS   = 4'd6;
  localparam logic [3:0] S_APPEND = 4'd7;
  localparam logic [3:0] S_LINK   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  // memories
  bkt_entry_t   bkt_mem_r   [BUCKETS];
  store_entry_t store_mem_r [MAX_FACES];
  bkt_entry_t   bkt_rdata_r;
  store_entry_t store_rdata_r;

  logic                 bkt_we, bkt_re;
  logic [BKT_BITS-1:0]  bkt_waddr;
  bkt_entry_t           bkt_wdata;
  logic                 store_we, store_re;
  logic [SLOT_BITS-1:0] store_waddr, store_raddr;
  store_entry_t         store_wdata;

  // control
  logic [3:0]           state_r, state_nxt;
  logic                 clr_busy_r;
  logic [BKT_BITS-1:0]  clr_idx_r;
  logic [SIZE_BITS-1:0] table_size_r;
  logic [CNT_BITS-1:0]  entries_r;
  logic [PAIR_BITS-1:0] pairs_r;
  logic                 out_valid_r;

  // per-item working registers
  logic [POINT_BITS-1:0] a_r, b_r;
  logic [ELEM_BITS-1:0]  elem_r;
  logic [31:0]           frac_r;
  logic [BKT_BITS-1:0]   bk_r;
  logic [CNT_BITS-1:0]   len_r, k_r;
  logic [SLOT_BITS-1:0]  head_r, cur_r, slot_r;
  logic                  hit_r, ovf_r;
  logic [ELEM_BITS-1:0]  hit_elem_r;
  logic [POINT_BITS-1:0] hit_start_r, hit_end_r;

  // output register
  logic [95:0] out_data_r;
  logic [1:0]  out_user_r;

  logic                  in_fire, out_load;
  logic [POINT_BITS:0]   sum_w;
  logic [52:0]           prod1_w;
  logic [31+SIZE_BITS:0] prod2_w;
  logic                  entry_match, chain_last;
  logic [SIZE_BITS-1:0]  size_clamped;

  assign in_tready  = (state_r == S_IDLE) && !clr_busy_r;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_load   = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // hash datapath, a register after each multiply
  assign sum_w   = {1'b0, a_r} + {1'b0, b_r};
  assign prod1_w = 53'(sum_w) * 53'(GOLDEN_Q32);
  assign prod2_w = (32+SIZE_BITS)'(frac_r) * (32+SIZE_BITS)'(table_size_r);

  assign entry_match = !store_rdata_r.paired && (store_rdata_r.start_pt == b_r) &&
                       (store_rdata_r.end_pt == a_r);
  assign chain_last  = (CNT_BITS'(k_r + 1'b1) == len_r);

  always_comb begin
    if (cfg_wdata == '0) begin
      size_clamped = SIZE_BITS'(1);
    end else if (cfg_wdata > SIZE_BITS'(BUCKETS)) begin
      size_clamped = SIZE_BITS'(BUCKETS);
    end else begin
      size_clamped = cfg_wdata;
    end
  end

  // memory port control
  always_comb begin
    bkt_we      = 1'b0;
    bkt_waddr   = bk_r;
    bkt_wdata   = '0;
    bkt_re      = (state_r == S_BREAD);
    store_we    = 1'b0;
    store_waddr = cur_r;
    store_wdata = store_rdata_r;
    store_re    = 1'b0;
    store_raddr = head_r;
    if (clr_busy_r) begin
      bkt_we    = 1'b1;
      bkt_waddr = clr_idx_r;
    end else if (state_r == S_APPEND) begin
      bkt_we          = 1'b1;
      bkt_wdata.count = CNT_BITS'(len_r + 1'b1);
      bkt_wdata.head  = (len_r == '0) ? slot_r : head_r;
    end
    unique case (state_r)
      S_BWAIT: begin
        store_re    = (bkt_rdata_r.count != '0);
        store_raddr = bkt_rdata_r.head;
      end
      S_WALK: begin
        if (entry_match) begin
          store_we           = 1'b1;
          store_wdata.paired = 1'b1;
        end else if (!chain_last) begin
          store_re    = 1'b1;
          store_raddr = store_rdata_r.link;
        end
      end
      S_APPEND: begin
        store_we             = 1'b1;
        store_waddr          = slot_r;
        store_wdata.start_pt = a_r;
        store_wdata.end_pt   = b_r;
        store_wdata.element  = elem_r;
        store_wdata.paired   = 1'b0;
        store_wdata.link     = '0;
      end
      S_LINK: begin
        // tail entry still sits in the read register
        store_we         = 1'b1;
        store_wdata.link = slot_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (bkt_we) begin
      bkt_mem_r[bkt_waddr] <= bkt_wdata;
    end
    if (bkt_re) begin
      bkt_rdata_r <= bkt_mem_r[bk_r];
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem_r[store_waddr] <= store_wdata;
    end
    if (store_re) begin
      store_rdata_r <= store_mem_r[store_raddr];
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_fire) state_nxt = S_MUL1;
      S_MUL1:   state_nxt = S_MUL2;
      S_MUL2:   state_nxt = S_BREAD;
      S_BREAD:  state_nxt = S_BWAIT;
      S_BWAIT:  state_nxt = (bkt_rdata_r.count == '0) ? S_MISS : S_WALK;
      S_WALK: begin
        if (entry_match) begin
          state_nxt = S_DONE;
        end else if (chain_last) begin
          state_nxt = S_MISS;
        end
      end
      S_MISS:   state_nxt = (entries_r == CNT_BITS'(MAX_FACES)) ? S_DONE : S_APPEND;
      S_APPEND: state_nxt = (len_r == '0) ? S_DONE : S_LINK;
      S_LINK:   state_nxt = S_DONE;
      S_DONE:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      clr_busy_r   <= 1'b1;
      clr_idx_r    <= '0;
      table_size_r <= SIZE_BITS'(BUCKETS);
      entries_r    <= '0;
      pairs_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_busy_r) begin
        clr_idx_r <= BKT_BITS'(clr_idx_r + 1'b1);
        if (clr_idx_r == {BKT_BITS{1'b1}}) begin
          clr_busy_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        table_size_r <= size_clamped;
      end
      if (state_r == S_APPEND) begin
        entries_r <= CNT_BITS'(entries_r + 1'b1);
      end
      if ((state_r == S_WALK) && entry_match && (pairs_r != COUNT_MAX)) begin
        pairs_r <= PAIR_BITS'(pairs_r + 1'b1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_r    <= in_tdata[POINT_BITS-1:0];
      b_r    <= in_tdata[2*POINT_BITS-1:POINT_BITS];
      elem_r <= in_tdata[2*POINT_BITS+ELEM_BITS-1:2*POINT_BITS];
      hit_r  <= 1'b0;
      ovf_r  <= 1'b0;
    end
    if (state_r == S_MUL1) begin
      frac_r <= prod1_w[31:0];
    end
    if (state_r == S_MUL2) begin
      bk_r <= prod2_w[32+BKT_BITS-1:32];
    end
    if (state_r == S_BWAIT) begin
      len_r  <= bkt_rdata_r.count;
      head_r <= bkt_rdata_r.head;
      cur_r  <= bkt_rdata_r.head;
      k_r    <= '0;
    end
    if ((state_r == S_WALK) && !entry_match && !chain_last) begin
      cur_r <= store_rdata_r.link;
      k_r   <= CNT_BITS'(k_r + 1'b1);
    end
    if ((state_r == S_WALK) && entry_match) begin
      hit_r       <= 1'b1;
      hit_elem_r  <= store_rdata_r.element;
      hit_start_r <= store_rdata_r.start_pt;
      hit_end_r   <= store_rdata_r.end_pt;
    end
    if (state_r == S_MISS) begin
      slot_r <= entries_r[SLOT_BITS-1:0];
      ovf_r  <= (entries_r == CNT_BITS'(MAX_FACES));
    end
    if (out_load) begin
      out_data_r[19:0]  <= hit_r ? hit_elem_r : '0;
      out_data_r[39:20] <= elem_r;
      out_data_r[59:40] <= hit_r ? hit_start_r : '0;
      out_data_r[79:60] <= hit_r ? hit_end_r : '0;
      out_data_r[92:80] <= pairs_r;
      out_data_r[95:93] <= '0;
      out_user_r        <= {ovf_r, hit_r};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/mfpm_checker.sv -----
// port-level checker for the mesh face pair matcher
// bound to mesh_face_pair_matcher_top; no package dependency
`default_nettype none

module mfpm_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [95:0] out_tdata,
  input wire [1:0]  out_tuser
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // the bucket sweep keeps the input closed right after reset
  a_clear_blocks: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("input open or result shown right after reset");

  // an edge is either paired or dropped, never both
  a_match_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("matched and overflow both set");

  // unmatched results carry no stored edge
  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      (out_tdata[19:0] == 20'd0) && (out_tdata[79:40] == 40'd0))
    else $error("stored edge fields set without a match");

  // padding bits stay zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[95:93] == 3'd0)
    else $error("result padding not zero");

endmodule

bind mesh_face_pair_matcher_top mfpm_checker u_mfpm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
